FILE: rtl/core/tlvaf_pkg.sv
// Shared types and constants for the TLV attribute finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tlvaf_pkg;

	localparam int MAX_VALUE_LEN = 1024;
	localparam int CODE_W        = 16;
	localparam int BYTE_W        = 8;
	localparam int VLEN_W        = 11;
	localparam int STATUS_W      = 3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_END     = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_BUSY     = 3'd0,
		ST_OK       = 3'd1,
		ST_BADCODE  = 3'd2,
		ST_BADLEN   = 3'd3,
		ST_BADDATA  = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
	} q_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

FILE: rtl/core/tlvaf_front.sv
// Front end: takes input beats, classifies them into scanner operations.
// Depends on tlvaf_pkg.
`timescale 1ns / 1ps

module tlvaf_front (
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tlvaf_pkg::BYTE_W-1:0] data_byte,
	input  logic                        at_end,
	input  logic                        restart,
	input  tlvaf_pkg::q_status_t        q_st,
	output logic                        push,
	output tlvaf_pkg::q_entry_t         entry
);
	import tlvaf_pkg::*;

	assign in_stall = q_st.full;
	assign push     = in_valid && !q_st.full;

	// restart takes precedence over end of stream
	always_comb begin
		entry.data = data_byte;
		if (restart) begin
			entry.op = OP_RESTART;
		end else if (at_end) begin
			entry.op = OP_END;
		end else begin
			entry.op = OP_BYTE;
		end
	end

endmodule

FILE: rtl/core/tlvaf_queue.sv
// Short FIFO of classified operations between front end and scanner.
// Depends on tlvaf_pkg.
`timescale 1ns / 1ps

module tlvaf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tlvaf_pkg::q_entry_t  wr_entry,
	input  logic                 pop,
	output tlvaf_pkg::q_entry_t  rd_entry,
	output tlvaf_pkg::q_status_t q_st
);
	import tlvaf_pkg::*;

	q_entry_t            entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QPTR_W'(1);
		end
		return r;
	endfunction

	assign q_st.empty = (count_q == '0);
	assign q_st.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign do_push    = push && !q_st.full;
	assign do_pop     = pop && !q_st.empty;
	assign rd_entry   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/core/tlvaf_scan.sv
// Back end: record scanner state machine with registered result beat.
// Depends on tlvaf_pkg; fed from tlvaf_queue.
`timescale 1ns / 1ps

module tlvaf_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tlvaf_pkg::q_entry_t            op_entry,
	input  tlvaf_pkg::q_status_t           q_st,
	output logic                           pop,
	input  logic [tlvaf_pkg::CODE_W-1:0]   wanted_code,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           kind,
	output logic [tlvaf_pkg::BYTE_W-1:0]   value_byte,
	output logic [tlvaf_pkg::VLEN_W-1:0]   value_length,
	output logic [tlvaf_pkg::STATUS_W-1:0] status,
	output logic                           last
);
	import tlvaf_pkg::*;

	typedef enum logic [2:0] {
		PH_CODE  = 3'd0,
		PH_PSIZE = 3'd1,
		PH_LEN   = 3'd2,
		PH_SKIP  = 3'd3,
		PH_DATA  = 3'd4
	} phase_t;

	phase_t              phase_q,    phase_n;
	logic [3:0]          cnt_q,      cnt_n;
	logic [CODE_W-1:0]   code_q,     code_n;
	logic [CODE_W-1:0]   len_q,      len_n;
	logic [63:0]         skip_q,     skip_n;
	logic                finished_q, finished_n;

	logic                out_valid_q;
	logic                kind_q,   kind_n;
	logic [BYTE_W-1:0]   vbyte_q,  vbyte_n;
	logic [VLEN_W-1:0]   vlen_q,   vlen_n;
	status_t             status_q, status_n;
	logic                last_q,   last_n;
	logic                emit;

	logic [CODE_W-1:0]   code_sh;
	logic [CODE_W-1:0]   len_sh;
	logic [63:0]         skip_sh;
	logic [63:0]         skip_dec;
	logic [3:0]          cnt_inc;

	assign pop = !q_st.empty && (!out_valid_q || !out_stall);

	assign code_sh  = {code_q[CODE_W-BYTE_W-1:0], op_entry.data};
	assign len_sh   = {len_q[CODE_W-BYTE_W-1:0], op_entry.data};
	assign skip_sh  = {skip_q[63-BYTE_W:0], op_entry.data};
	assign skip_dec = (skip_q != '0) ? skip_q - 64'd1 : skip_q;
	assign cnt_inc  = cnt_q + 4'd1;

	always_comb begin
		phase_n    = phase_q;
		cnt_n      = cnt_q;
		code_n     = code_q;
		len_n      = len_q;
		skip_n     = skip_q;
		finished_n = finished_q;
		emit       = 1'b0;
		kind_n     = 1'b1;
		vbyte_n    = '0;
		vlen_n     = '0;
		status_n   = ST_BUSY;
		last_n     = 1'b0;

		if (pop) begin
			case (op_entry.op)
				OP_RESTART: begin
					phase_n    = PH_CODE;
					cnt_n      = '0;
					code_n     = '0;
					len_n      = '0;
					skip_n     = '0;
					finished_n = 1'b0;
				end
				OP_END: begin
					if (!finished_q) begin
						emit       = 1'b1;
						last_n     = 1'b1;
						finished_n = 1'b1;
						case (phase_q)
							PH_PSIZE, PH_LEN: status_n = ST_BADLEN;
							PH_DATA:          status_n = ST_BADDATA;
							default:          status_n = ST_BADCODE;
						endcase
					end
				end
				OP_BYTE: begin
					if (!finished_q) begin
						case (phase_q)
							PH_CODE: begin
								code_n = code_sh;
								if (cnt_q == '0) begin
									cnt_n = 4'd1;
								end else begin
									cnt_n = '0;
									if (code_sh == '0) begin
										emit       = 1'b1;
										last_n     = 1'b1;
										status_n   = ST_NOTFOUND;
										finished_n = 1'b1;
									end else if (code_sh == CODE_W'(1)) begin
										phase_n = PH_PSIZE;
										skip_n  = '0;
									end else begin
										phase_n = PH_LEN;
										len_n   = '0;
									end
								end
							end
							PH_PSIZE: begin
								skip_n = skip_sh;
								cnt_n  = cnt_inc;
								if (cnt_inc >= 4'd8) begin
									cnt_n   = '0;
									phase_n = (skip_sh == '0) ? PH_CODE : PH_SKIP;
								end
							end
							PH_LEN: begin
								len_n = len_sh;
								if (cnt_q == '0) begin
									cnt_n = 4'd1;
								end else begin
									cnt_n = '0;
									if (len_sh == '0 || len_sh > CODE_W'(MAX_VALUE_LEN)) begin
										emit       = 1'b1;
										last_n     = 1'b1;
										status_n   = ST_BADLEN;
										finished_n = 1'b1;
									end else begin
										skip_n  = {{(64-CODE_W){1'b0}}, len_sh};
										phase_n = (code_q == wanted_code) ? PH_DATA : PH_SKIP;
									end
								end
							end
							PH_SKIP: begin
								skip_n = skip_dec;
								if (skip_dec == '0) begin
									phase_n = PH_CODE;
								end
							end
							PH_DATA: begin
								skip_n  = skip_dec;
								emit    = 1'b1;
								kind_n  = 1'b0;
								vbyte_n = op_entry.data;
								if (skip_dec == '0) begin
									vlen_n     = len_q[VLEN_W-1:0];
									status_n   = ST_OK;
									last_n     = 1'b1;
									finished_n = 1'b1;
								end
							end
							default: begin
								phase_n = PH_CODE;
								cnt_n   = '0;
							end
						endcase
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CODE;
			cnt_q       <= '0;
			code_q      <= '0;
			len_q       <= '0;
			skip_q      <= '0;
			finished_q  <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= 1'b0;
			vbyte_q     <= '0;
			vlen_q      <= '0;
			status_q    <= ST_BUSY;
			last_q      <= 1'b0;
		end else begin
			phase_q    <= phase_n;
			cnt_q      <= cnt_n;
			code_q     <= code_n;
			len_q      <= len_n;
			skip_q     <= skip_n;
			finished_q <= finished_n;
			if (emit) begin
				out_valid_q <= 1'b1;
				kind_q      <= kind_n;
				vbyte_q     <= vbyte_n;
				vlen_q      <= vlen_n;
				status_q    <= status_n;
				last_q      <= last_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign value_byte   = vbyte_q;
	assign value_length = vlen_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

FILE: rtl/core/tlv_attribute_finder.sv
// Top level of the TLV attribute finder: front end, operation queue, scanner.
// Depends on tlvaf_pkg, tlvaf_front, tlvaf_queue and tlvaf_scan.
`timescale 1ns / 1ps

// Scans a stream of type-length-value records, one byte per input beat, for
// the record whose code equals wanted_code, and returns its value bytes one
// beat each, the last with status ok and the length; end of stream, a bad
// length or the end code give a single status beat instead. The block takes
// one beat every cycle while in_stall is low: each byte is one step of the
// scanner state machine once it leaves the queue; its result is registered. A
// two-entry queue sits between the input classifier and the scanner, and the
// result beat is held in an output register, so each side can stall alone.
// wanted_code is sampled when a record's length completes; write it only
// while the block is idle.

module tlv_attribute_finder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tlvaf_pkg::CODE_W-1:0]   cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [tlvaf_pkg::BYTE_W-1:0]   data_byte,
	input  logic                           at_end,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           kind,
	output logic [tlvaf_pkg::BYTE_W-1:0]   value_byte,
	output logic [tlvaf_pkg::VLEN_W-1:0]   value_length,
	output logic [tlvaf_pkg::STATUS_W-1:0] status,
	output logic                           last
);
	import tlvaf_pkg::*;

	logic [CODE_W-1:0] wanted_code_q;
	q_status_t         q_st;
	q_entry_t          wr_entry;
	q_entry_t          rd_entry;
	logic              push;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_code_q <= CODE_W'(2);
		end else if (cfg_wr_en) begin
			wanted_code_q <= cfg_wr_data;
		end
	end

	tlvaf_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.at_end    (at_end),
		.restart   (restart),
		.q_st      (q_st),
		.push      (push),
		.entry     (wr_entry)
	);

	tlvaf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.q_st     (q_st)
	);

	tlvaf_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_entry     (rd_entry),
		.q_st         (q_st),
		.pop          (pop),
		.wanted_code  (wanted_code_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.value_byte   (value_byte),
		.value_length (value_length),
		.status       (status),
		.last         (last)
	);

	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> last && value_byte == '0 && value_length == '0
		&& status != ST_BUSY && status != ST_OK)
		else $error("status beat malformed");

	a_value_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> (last && status == ST_OK && value_length != '0)
		|| (!last && status == ST_BUSY && value_length == '0))
		else $error("value beat malformed");

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_st.empty && q_st.full))
		else $error("queue empty and full together");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_st.empty && !(out_valid && out_stall))
		else $error("scanner advanced without room or operation");

endmodule

FILE: bench/tlv_attribute_finder_test.sv
`timescale 1ns / 1ps
// Self-checking bench for tlv_attribute_finder: directed probes, then random record streams
// under random idling on both sides, each result beat checked against an in-bench scanner.
// Depends on tlvaf_pkg and the RTL of tlv_attribute_finder.

module tlv_attribute_finder_test;
	import tlvaf_pkg::*;

	localparam int RANDOM_BEATS = 700;
	localparam int PHASES       = 5;
	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 2000000;

	typedef enum logic [2:0] {
		SCAN_CODE,
		SCAN_PSIZE,
		SCAN_LEN,
		SCAN_SKIP,
		SCAN_DATA
	} scan_phase_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] vbyte;
		logic [VLEN_W-1:0] vlen;
		status_t           st;
		logic              last;
	} outcome_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              stream_end;
		logic              restart_req;
		logic              pinned;
		logic              pinned_has;
		outcome_t          pinned_res;
	} beat_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CODE_W-1:0]   cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic [BYTE_W-1:0]   data_byte;
	logic                at_end;
	logic                restart;
	logic                out_valid;
	logic                out_stall;
	logic                kind;
	logic [BYTE_W-1:0]   value_byte;
	logic [VLEN_W-1:0]   value_length;
	logic [STATUS_W-1:0] status;
	logic                last;

	scan_phase_t       scan_phase;
	int                scan_count;
	logic [CODE_W-1:0] scan_code;
	logic [CODE_W-1:0] scan_len;
	logic [CODE_W-1:0] scan_wanted;
	logic [63:0]       scan_skip;
	bit                scan_done;

	outcome_t awaited_results[$];
	beat_t    stream_q[$];
	int       mismatches = 0;
	int       beats_sent = 0;
	int       cycle_count = 0;
	bit       long_hold_req = 1'b0;
	bit       in_calm = 1'b0;
	int       in_calm_left = 0;

	tlv_attribute_finder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.at_end       (at_end),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.value_byte   (value_byte),
		.value_length (value_length),
		.status       (status),
		.last         (last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] MISMATCH %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [10:0] got,
			input logic [10:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
	endtask

	function automatic void clear_search();
		scan_phase = SCAN_CODE;
		scan_count = 0;
		scan_code = '0;
		scan_len = '0;
		scan_skip = '0;
		scan_done = 1'b0;
	endfunction

	function automatic void close_search(input status_t st, output outcome_t res);
		scan_done = 1'b1;
		res = '0;
		res.kind = 1'b1;
		res.st = st;
		res.last = 1'b1;
	endfunction

	// advance the scanner by one beat; returns 1 when the beat yields a result
	function automatic bit scan_byte(input logic [BYTE_W-1:0] b, input logic stream_end,
			input logic restart_req, output outcome_t res);
		res = '0;
		if (restart_req) begin
			clear_search();
			return 1'b0;
		end
		if (scan_done)
			return 1'b0;
		if (stream_end) begin
			case (scan_phase)
				SCAN_PSIZE, SCAN_LEN: close_search(ST_BADLEN, res);
				SCAN_DATA: close_search(ST_BADDATA, res);
				default: close_search(ST_BADCODE, res);
			endcase
			return 1'b1;
		end
		case (scan_phase)
			SCAN_CODE: begin
				scan_code = {scan_code[7:0], b};
				if (scan_count == 0) begin
					scan_count = 1;
					return 1'b0;
				end
				scan_count = 0;
				if (scan_code == 16'd0) begin
					close_search(ST_NOTFOUND, res);
					return 1'b1;
				end
				if (scan_code == 16'd1) begin
					scan_phase = SCAN_PSIZE;
					scan_skip = '0;
				end else begin
					scan_phase = SCAN_LEN;
					scan_len = '0;
				end
			end
			SCAN_PSIZE: begin
				scan_skip = {scan_skip[55:0], b};
				scan_count++;
				if (scan_count >= 8) begin
					scan_count = 0;
					scan_phase = (scan_skip == 0) ? SCAN_CODE : SCAN_SKIP;
				end
			end
			SCAN_LEN: begin
				scan_len = {scan_len[7:0], b};
				if (scan_count == 0) begin
					scan_count = 1;
					return 1'b0;
				end
				scan_count = 0;
				if (scan_len == 0 || scan_len > MAX_VALUE_LEN) begin
					close_search(ST_BADLEN, res);
					return 1'b1;
				end
				scan_skip = 64'(scan_len);
				scan_phase = (scan_code == scan_wanted) ? SCAN_DATA : SCAN_SKIP;
			end
			SCAN_SKIP: begin
				if (scan_skip != 0)
					scan_skip--;
				if (scan_skip == 0)
					scan_phase = SCAN_CODE;
			end
			default: begin
				if (scan_skip != 0)
					scan_skip--;
				res.vbyte = b;
				if (scan_skip == 0) begin
					scan_done = 1'b1;
					res.vlen = scan_len[VLEN_W-1:0];
					res.st = ST_OK;
					res.last = 1'b1;
				end
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic beat_t plain_beat(input logic [BYTE_W-1:0] data, input logic stream_end,
			input logic restart_req);
		beat_t bt;
		bt = '0;
		bt.data = data;
		bt.stream_end = stream_end;
		bt.restart_req = restart_req;
		return bt;
	endfunction

	function automatic void push_beat(input logic [BYTE_W-1:0] data, input logic stream_end,
			input logic restart_req);
		stream_q.push_back(plain_beat(data, stream_end, restart_req));
	endfunction

	function automatic void push_pinned(input logic [BYTE_W-1:0] data, input logic stream_end,
			input logic restart_req, input logic has, input logic k, input logic [7:0] vb,
			input logic [10:0] vl, input status_t st, input logic lst);
		beat_t bt;
		bt = plain_beat(data, stream_end, restart_req);
		bt.pinned = 1'b1;
		bt.pinned_has = has;
		bt.pinned_res.kind = k;
		bt.pinned_res.vbyte = vb;
		bt.pinned_res.vlen = vl;
		bt.pinned_res.st = st;
		bt.pinned_res.last = lst;
		stream_q.push_back(bt);
	endfunction

	function automatic void push_word(input logic [15:0] w);
		push_beat(w[15:8], 1'b0, 1'b0);
		push_beat(w[7:0], 1'b0, 1'b0);
	endfunction

	function automatic void push_random_bytes(input int n);
		repeat (n) push_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
	endfunction

	function automatic int value_len();
		if ($urandom_range(0, 199) == 0)
			return MAX_VALUE_LEN;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(13, 64);
		return $urandom_range(1, 12);
	endfunction

	// a code that neither ends the stream, opens a payload nor matches
	function automatic logic [15:0] other_code();
		logic [15:0] c;
		c = 16'd0;
		while (c <= 16'd1 || c == scan_wanted) begin
			if ($urandom_range(0, 1) == 1)
				c = scan_wanted ^ (16'd1 << $urandom_range(0, 15));
			else
				c = 16'($urandom);
		end
		return c;
	endfunction

	function automatic void push_record(input logic [15:0] code);
		int len;
		len = value_len();
		push_word(code);
		push_word(16'(len));
		push_random_bytes(len);
	endfunction

	function automatic void build_search();
		int pick;
		int cut;
		logic [63:0] psize;
		stream_q.delete();
		if ($urandom_range(0, 9) != 0)
			push_beat(8'($urandom), 1'($urandom), 1'b1);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(3, 24))
				push_beat(8'($urandom), $urandom_range(0, 15) == 0, $urandom_range(0, 31) == 0);
			return;
		end
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 2) == 0) begin
				psize = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(13, 60)) :
					64'($urandom_range(0, 12));
				push_word(16'd1);
				for (int k = 7; k >= 0; k--)
					push_beat(psize[8*k +: 8], 1'b0, 1'b0);
				push_random_bytes(int'(psize));
			end else begin
				push_record(other_code());
			end
		end
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			if (scan_wanted > 16'd1) begin
				push_record(scan_wanted);
			end else begin
				push_record(other_code());
				push_word(16'd0);
			end
		end else if (pick < 7) begin
			push_word(16'd0);
		end else if (pick == 7) begin
			push_word(other_code());
			push_word(($urandom_range(0, 1) == 1) ? 16'd0 :
				16'($urandom_range(MAX_VALUE_LEN + 1, 65535)));
		end else begin
			push_beat(8'($urandom), 1'b1, 1'b0);
		end
		if ($urandom_range(0, 3) == 0 && stream_q.size() > 1) begin
			cut = $urandom_range(1, stream_q.size() - 1);
			while (stream_q.size() > cut)
				void'(stream_q.pop_back());
			push_beat(8'($urandom), 1'b1, 1'b0);
		end
		repeat ($urandom_range(0, 2)) push_beat(8'($urandom), 1'($urandom), 1'b0);
	endfunction

	function automatic int pick_gap(input bit calm);
		int p;
		p = $urandom_range(0, 99);
		if (calm || p < 60)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic drive_beat(input beat_t bt);
		int gap;
		bit produced;
		outcome_t res;
		if (in_calm_left == 0) begin
			in_calm = ($urandom_range(0, 3) == 0);
			in_calm_left = $urandom_range(30, 150);
		end
		in_calm_left--;
		gap = pick_gap(in_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= bt.data;
		at_end <= bt.stream_end;
		restart <= bt.restart_req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
		produced = scan_byte(bt.data, bt.stream_end, bt.restart_req, res);
		if (bt.pinned) begin
			produced = bt.pinned_has;
			res = bt.pinned_res;
		end
		if (produced)
			awaited_results.push_back(res);
	endtask

	task automatic send_stream(input int hold_at);
		for (int i = 0; i < stream_q.size(); i++) begin
			if (i == hold_at)
				long_hold_req = 1'b1;
			drive_beat(stream_q[i]);
		end
	endtask

	// drop valid, drain every awaited result, then let in-flight beats retire
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_wanted(input logic [15:0] code);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		scan_wanted = code;
	endtask

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, kind %0d status %0d", kind, status));
			end else begin
				want = awaited_results.pop_front();
				check_field("kind", 11'(kind), 11'(want.kind));
				check_field("value_byte", 11'(value_byte), 11'(want.vbyte));
				check_field("value_length", value_length, want.vlen);
				check_field("status", 11'(status), 11'(want.st));
				check_field("last", 11'(last), 11'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[%0t] timeout, %0d results still awaited", $time, awaited_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : out_pacing
		bit calm;
		int calm_left;
		int n;
		calm = 1'b0;
		calm_left = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(50, 200);
			end
			calm_left--;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				n = pick_gap(calm);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		logic [15:0] plan [PHASES];
		int quota;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		at_end = 1'b0;
		restart = 1'b0;
		scan_wanted = 16'd2;
		clear_search();
		plan[0] = 16'hFFFF;
		plan[1] = 16'h0000;
		plan[2] = 16'h0001;
		plan[3] = 16'($urandom_range(2, 65534));
		plan[4] = 16'h0002;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stream end, then beats and an end after the final status
		stream_q.delete();
		push_pinned(8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00, 11'd0, ST_BADCODE, 1'b1);
		push_pinned(8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 11'd0, ST_BUSY, 1'b0);
		push_pinned(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 11'd0, ST_BUSY, 1'b0);
		// restart wins over end
		push_pinned(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 11'd0, ST_BUSY, 1'b0);
		// matching record at the reset code, two value bytes
		push_word(16'd2);
		push_word(16'd2);
		push_pinned(8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 11'd0, ST_BUSY, 1'b0);
		push_pinned(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 11'd2, ST_OK, 1'b1);
		// payload of one byte skipped, then the end code
		push_beat(8'h00, 1'b0, 1'b1);
		push_word(16'd1);
		repeat (7) push_beat(8'h00, 1'b0, 1'b0);
		push_beat(8'h01, 1'b0, 1'b0);
		push_beat(8'h5A, 1'b0, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		push_pinned(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 11'd0, ST_NOTFOUND, 1'b1);
		// zero length
		push_beat(8'h00, 1'b0, 1'b1);
		push_word(16'hFFFF);
		push_beat(8'h00, 1'b0, 1'b0);
		push_pinned(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 11'd0, ST_BADLEN, 1'b1);
		send_stream(-1);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			load_wanted(plan[p]);
			quota = beats_sent + RANDOM_BEATS / PHASES;
			if (p == 0) begin
				// longest value while the receiver holds off
				stream_q.delete();
				push_beat(8'($urandom), 1'b0, 1'b1);
				push_word(16'hFFFF);
				push_word(16'(MAX_VALUE_LEN));
				push_random_bytes(MAX_VALUE_LEN);
				send_stream(5);
			end
			while (beats_sent < quota) begin
				build_search();
				send_stream(-1);
			end
		end
		settle();

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
